### sv/can_mcf_pkg.sv
`default_nettype none

package can_mcf_pkg;

  localparam int unsigned MaxMotors     = 4;
  localparam int unsigned MotorCountDef = 4;

  localparam int unsigned IdW     = 11;
  localparam int unsigned AgeW    = 16;
  localparam int unsigned DutyW   = 15;
  localparam int unsigned LenW    = 4;
  localparam int unsigned DataW   = 64;
  localparam int unsigned CmdW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [IdW-1:0]   OWN_ID_RESET  = 11'd320;
  localparam logic [AgeW-1:0]  TIMEOUT_RESET = 16'd50;
  localparam logic [DutyW-1:0] PWM_TOP_RESET = 15'd32767;
  localparam logic [AgeW-1:0]  AGE_MAX       = 16'hFFFF;
  localparam logic [DutyW-1:0] CMD_LIMIT     = 15'd32767;
  localparam logic [LenW-1:0]  MIN_CMD_BYTES = 4'd8;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_ID  = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_PWM_TOP = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             req_type;
    logic [IdW-1:0]   frame_id;
    logic             frame_extended;
    logic [LenW-1:0]  frame_len;
    logic [DataW-1:0] payload;
  } item_t;

  typedef struct packed {
    logic [IdW-1:0]   own_id;
    logic [AgeW-1:0]  timeout_ticks;
    logic [DutyW-1:0] pwm_top;
  } cfg_t;

  typedef struct packed {
    logic [AgeW-1:0] any_age;
    logic [AgeW-1:0] own_age;
  } age_status_t;

endpackage

`default_nettype wire

### sv/can_motor_command_failsafe_top.sv
// Channel  Handshake                 Beat carries
// in       in_valid / in_ready       req_type, frame_id, frame_extended, frame_len, payload
// out      out_valid / out_ready     motor0..3 fwd/back duties, led_a_level, led_b_level
// cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Every input beat gives one result beat, after the input register and the state registers.
// One beat per cycle sustained while out_ready stays high: an input register feeds the state update,
// and the state registers double as the result register.
// Reset clears ages, duties and LEDs and loads the register defaults.
// An output stall holds the state; the input register takes one more beat.
`default_nettype none

module can_motor_command_failsafe_top #(
  parameter int unsigned MOTOR_COUNT = can_mcf_pkg::MotorCountDef
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                req_type,
  input  wire logic [can_mcf_pkg::IdW-1:0]         frame_id,
  input  wire logic                                frame_extended,
  input  wire logic [can_mcf_pkg::LenW-1:0]        frame_len,
  input  wire logic [can_mcf_pkg::DataW-1:0]       payload,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [can_mcf_pkg::DutyW-1:0]            motor0_fwd_duty,
  output logic [can_mcf_pkg::DutyW-1:0]            motor0_back_duty,
  output logic [can_mcf_pkg::DutyW-1:0]            motor1_fwd_duty,
  output logic [can_mcf_pkg::DutyW-1:0]            motor1_back_duty,
  output logic [can_mcf_pkg::DutyW-1:0]            motor2_fwd_duty,
  output logic [can_mcf_pkg::DutyW-1:0]            motor2_back_duty,
  output logic [can_mcf_pkg::DutyW-1:0]            motor3_fwd_duty,
  output logic [can_mcf_pkg::DutyW-1:0]            motor3_back_duty,
  output logic                                     led_a_level,
  output logic                                     led_b_level,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [can_mcf_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [can_mcf_pkg::CfgDatW-1:0]     cfg_data
);
  import can_mcf_pkg::*;

  cfg_t        cfg;
  item_t       in_q;
  logic        in_q_valid;
  logic        advance;
  age_status_t status;
  logic [DutyW-1:0] fwd_duty  [MaxMotors];
  logic [DutyW-1:0] back_duty [MaxMotors];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id        <= OWN_ID_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.pwm_top       <= PWM_TOP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ID:  cfg.own_id        <= cfg_data[IdW-1:0];
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data[AgeW-1:0];
        CFG_PWM_TOP: cfg.pwm_top       <= cfg_data[DutyW-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) in_q_valid <= in_valid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.req_type       <= req_type;
      in_q.frame_id       <= frame_id;
      in_q.frame_extended <= frame_extended;
      in_q.frame_len      <= frame_len;
      in_q.payload        <= payload;
    end
  end

  can_mcf_core #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_q),
    .cfg       (cfg),
    .fwd_duty  (fwd_duty),
    .back_duty (back_duty),
    .led_a     (led_a_level),
    .led_b     (led_b_level),
    .status    (status)
  );

  assign motor0_fwd_duty  = fwd_duty[0];
  assign motor0_back_duty = back_duty[0];
  assign motor1_fwd_duty  = fwd_duty[1];
  assign motor1_back_duty = back_duty[1];
  assign motor2_fwd_duty  = fwd_duty[2];
  assign motor2_back_duty = back_duty[2];
  assign motor3_fwd_duty  = fwd_duty[3];
  assign motor3_back_duty = back_duty[3];

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed beat produced no result");

  a_led_not_both: assert property (@(posedge clk) disable iff (rst)
    !(led_a_level && led_b_level))
    else $error("both status LEDs high");

  a_own_age_ge_any: assert property (@(posedge clk) disable iff (rst)
    status.own_age >= status.any_age)
    else $error("own-traffic age below all-traffic age");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(status.any_age) && $stable(status.own_age))
    else $error("state changed while result stalled");

endmodule

`default_nettype wire

### sv/can_mcf_duty.sv
`default_nettype none

module can_mcf_duty (
  input  wire logic [can_mcf_pkg::CmdW-1:0]  cmd,
  input  wire logic [can_mcf_pkg::DutyW-1:0] pwm_top,
  output logic      [can_mcf_pkg::DutyW-1:0] fwd_duty,
  output logic      [can_mcf_pkg::DutyW-1:0] back_duty
);
  import can_mcf_pkg::*;

  logic [CmdW-1:0]  neg_cmd;
  logic [DutyW-1:0] mag;
  logic [DutyW-1:0] lim;

  assign neg_cmd = ~cmd + 16'd1;

  always_comb begin
    if (!cmd[CmdW-1]) begin
      mag = cmd[DutyW-1:0];
    end else if (cmd[DutyW-1:0] == '0) begin
      // most negative command clamps to the symmetric limit
      mag = CMD_LIMIT;
    end else begin
      mag = neg_cmd[DutyW-1:0];
    end
    lim       = (mag > pwm_top) ? pwm_top : mag;
    fwd_duty  = cmd[CmdW-1] ? '0 : lim;
    back_duty = cmd[CmdW-1] ? lim : '0;
  end

endmodule

`default_nettype wire

### sv/can_mcf_core.sv
`default_nettype none

module can_mcf_core #(
  parameter int unsigned MOTOR_COUNT = can_mcf_pkg::MotorCountDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire can_mcf_pkg::item_t  item,
  input  wire can_mcf_pkg::cfg_t   cfg,
  output logic [can_mcf_pkg::DutyW-1:0] fwd_duty  [can_mcf_pkg::MaxMotors],
  output logic [can_mcf_pkg::DutyW-1:0] back_duty [can_mcf_pkg::MaxMotors],
  output logic                     led_a,
  output logic                     led_b,
  output can_mcf_pkg::age_status_t status
);
  import can_mcf_pkg::*;

  logic [AgeW-1:0]  any_age;
  logic [AgeW-1:0]  own_age;
  logic [AgeW-1:0]  any_age_next;
  logic [AgeW-1:0]  own_age_next;
  logic             led_a_next;
  logic             led_b_next;
  logic [DutyW-1:0] fwd_next     [MaxMotors];
  logic [DutyW-1:0] back_next    [MaxMotors];
  logic [DutyW-1:0] fwd_decoded  [MaxMotors];
  logic [DutyW-1:0] back_decoded [MaxMotors];
  logic             frame_hit;

  for (genvar m = 0; m < MaxMotors; m++) begin : g_motor
    if (m < MOTOR_COUNT) begin : g_used
      can_mcf_duty u_duty (
        .cmd       (item.payload[CmdW*m +: CmdW]),
        .pwm_top   (cfg.pwm_top),
        .fwd_duty  (fwd_decoded[m]),
        .back_duty (back_decoded[m])
      );
    end else begin : g_unused
      assign fwd_decoded[m]  = '0;
      assign back_decoded[m] = '0;
    end
  end

  assign frame_hit = (item.req_type == REQ_FRAME) && !item.frame_extended &&
                     (item.frame_id == cfg.own_id);

  always_comb begin
    any_age_next = any_age;
    own_age_next = own_age;
    led_a_next   = led_a;
    led_b_next   = led_b;
    for (int m = 0; m < MaxMotors; m++) begin
      fwd_next[m]  = fwd_duty[m];
      back_next[m] = back_duty[m];
    end

    if (item.req_type == REQ_FRAME) begin
      any_age_next = '0;
      if (frame_hit) begin
        own_age_next = '0;
        led_a_next   = 1'b0;
        led_b_next   = 1'b1;
        for (int m = 0; m < MaxMotors; m++) begin
          if (item.frame_len >= MIN_CMD_BYTES) begin
            fwd_next[m]  = fwd_decoded[m];
            back_next[m] = back_decoded[m];
          end else begin
            fwd_next[m]  = '0;
            back_next[m] = '0;
          end
        end
      end
    end else begin
      if (any_age != AGE_MAX) any_age_next = any_age + 16'd1;
      if (own_age != AGE_MAX) own_age_next = own_age + 16'd1;
    end

    // failsafe: bus silence wins over own-id silence
    if (any_age_next > cfg.timeout_ticks) begin
      led_a_next = 1'b0;
      led_b_next = 1'b0;
    end else if (own_age_next > cfg.timeout_ticks) begin
      led_a_next = 1'b1;
      led_b_next = 1'b0;
    end
    if (any_age_next > cfg.timeout_ticks || own_age_next > cfg.timeout_ticks) begin
      for (int m = 0; m < MaxMotors; m++) begin
        fwd_next[m]  = '0;
        back_next[m] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_age <= '0;
      own_age <= '0;
      led_a   <= 1'b0;
      led_b   <= 1'b0;
      for (int m = 0; m < MaxMotors; m++) begin
        fwd_duty[m]  <= '0;
        back_duty[m] <= '0;
      end
    end else if (advance) begin
      any_age <= any_age_next;
      own_age <= own_age_next;
      led_a   <= led_a_next;
      led_b   <= led_b_next;
      for (int m = 0; m < MaxMotors; m++) begin
        fwd_duty[m]  <= fwd_next[m];
        back_duty[m] <= back_next[m];
      end
    end
  end

  assign status.any_age = any_age;
  assign status.own_age = own_age;

endmodule

`default_nettype wire

### verif/tb_top.sv
module tb_top;
  import can_mcf_pkg::*;

  localparam int unsigned ClockLimit = 1_000_000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned MaxReports = 40;
  localparam int unsigned DutySlots  = 2 * MaxMotors;
  localparam int unsigned SilenceTicks = 60;
  localparam logic [CfgIdxW-1:0] CfgNoReg   = 2'd3;
  localparam logic [CfgDatW-1:0] SilenceTimeout = 16'd20;

  typedef struct packed {
    logic [DutySlots-1:0][DutyW-1:0] duty;
    logic                            led_a;
    logic                            led_b;
  } drive_state_t;

  class drive_scoreboard;
    logic [IdW-1:0]   own_id;
    logic [AgeW-1:0]  timeout_ticks;
    logic [DutyW-1:0] pwm_top;
    logic [AgeW-1:0]  bus_age;
    logic [AgeW-1:0]  own_age;
    drive_state_t     held;
    drive_state_t     awaited_drive_q[$];
    int unsigned errors, ticks, own_full, own_short, other_frames;
    int unsigned bus_silent, own_silent, writes;

    function new();
      own_id        = OWN_ID_RESET;
      timeout_ticks = TIMEOUT_RESET;
      pwm_top       = PWM_TOP_RESET;
      bus_age       = '0;
      own_age       = '0;
      held          = '0;
    endfunction

    function void load_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
      writes++;
      case (idx)
        CFG_OWN_ID:  own_id = val[IdW-1:0];
        CFG_TIMEOUT: timeout_ticks = val[AgeW-1:0];
        CFG_PWM_TOP: pwm_top = val[DutyW-1:0];
        default: ;
      endcase
    endfunction

    function void drive_motor(int unsigned m, logic [CmdW-1:0] raw);
      logic [CmdW-1:0]  mag;
      logic [DutyW-1:0] lim;
      mag = raw[CmdW-1] ? -raw : raw;
      if (mag > CMD_LIMIT) mag = CMD_LIMIT;
      lim = (mag > pwm_top) ? pwm_top : mag[DutyW-1:0];
      held.duty[2*m]   = raw[CmdW-1] ? '0 : lim;
      held.duty[2*m+1] = raw[CmdW-1] ? lim : '0;
    endfunction

    function void note_beat(item_t it);
      if (it.req_type == REQ_FRAME) begin
        bus_age = '0;
        if (!it.frame_extended && it.frame_id == own_id) begin
          own_age    = '0;
          held.led_a = 1'b0;
          held.led_b = 1'b1;
          if (it.frame_len >= MIN_CMD_BYTES) begin
            own_full++;
            for (int m = 0; m < MotorCountDef; m++)
              drive_motor(m, it.payload[CmdW*m +: CmdW]);
          end else begin
            own_short++;
            held.duty = '0;
          end
        end else begin
          other_frames++;
        end
      end else begin
        ticks++;
        if (bus_age != AGE_MAX) bus_age++;
        if (own_age != AGE_MAX) own_age++;
      end
      if (bus_age > timeout_ticks) begin
        bus_silent++;
        held = '0;
      end else if (own_age > timeout_ticks) begin
        own_silent++;
        held.duty  = '0;
        held.led_a = 1'b1;
        held.led_b = 1'b0;
      end
      awaited_drive_q.push_back(held);
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_result(drive_state_t got);
      drive_state_t want;
      if (awaited_drive_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result beat with nothing awaited, actual %h", $time, got);
        return;
      end
      want = awaited_drive_q.pop_front();
      for (int s = 0; s < DutySlots; s++)
        if (got.duty[s] !== want.duty[s])
          report($sformatf("motor%0d %s duty", s / 2, (s % 2) ? "back" : "fwd"),
                 want.duty[s], got.duty[s]);
      if (got.led_a !== want.led_a) report("led_a_level", want.led_a, got.led_a);
      if (got.led_b !== want.led_b) report("led_b_level", want.led_b, got.led_b);
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                req_type = 1'b0;
  logic [IdW-1:0]      frame_id = '0;
  logic                frame_extended = 1'b0;
  logic [LenW-1:0]     frame_len = '0;
  logic [DataW-1:0]    payload = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DutyW-1:0]    motor0_fwd_duty, motor0_back_duty, motor1_fwd_duty, motor1_back_duty;
  logic [DutyW-1:0]    motor2_fwd_duty, motor2_back_duty, motor3_fwd_duty, motor3_back_duty;
  logic                led_a_level, led_b_level;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDatW-1:0]  cfg_data = '0;

  logic                idle_on = 1'b0;
  logic [7:0]          hold_asks = '0;
  logic [7:0]          hold_seen = '0;
  int unsigned         rx_left = 0;
  int unsigned         cycle_count = 0;

  drive_scoreboard drive_sb = new();

  can_motor_command_failsafe_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .frame_id         (frame_id),
    .frame_extended   (frame_extended),
    .frame_len        (frame_len),
    .payload          (payload),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .motor0_fwd_duty  (motor0_fwd_duty),
    .motor0_back_duty (motor0_back_duty),
    .motor1_fwd_duty  (motor1_fwd_duty),
    .motor1_back_duty (motor1_back_duty),
    .motor2_fwd_duty  (motor2_fwd_duty),
    .motor2_back_duty (motor2_back_duty),
    .motor3_fwd_duty  (motor3_fwd_duty),
    .motor3_back_duty (motor3_back_duty),
    .led_a_level      (led_a_level),
    .led_b_level      (led_b_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == ClockLimit) begin
      $display("%0t: run timed out with %0d results outstanding", $time,
               drive_sb.awaited_drive_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_left   <= 0;
      hold_seen <= '0;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      rx_left   <= LongHold - 1;
      out_ready <= 1'b0;
    end else if (rx_left != 0) begin
      rx_left   <= rx_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_left   <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      drive_sb.check_result(drive_state_t'({motor3_back_duty, motor3_fwd_duty,
                                            motor2_back_duty, motor2_fwd_duty,
                                            motor1_back_duty, motor1_fwd_duty,
                                            motor0_back_duty, motor0_fwd_duty,
                                            led_a_level, led_b_level}));
  end

  function automatic logic [DataW-1:0] cmds(logic [CmdW-1:0] c0, c1, c2, c3);
    return {c3, c2, c1, c0};
  endfunction

  function automatic item_t frame_item(logic [IdW-1:0] id, logic ext, logic [LenW-1:0] len,
                                       logic [DataW-1:0] data);
    item_t it;
    it.req_type       = REQ_FRAME;
    it.frame_id       = id;
    it.frame_extended = ext;
    it.frame_len      = len;
    it.payload        = data;
    return it;
  endfunction

  // Frame fields of a tick are don't-care; fill them with noise.
  function automatic item_t tick_item();
    item_t it;
    it = frame_item(IdW'($urandom), 1'($urandom), LenW'($urandom), {$urandom, $urandom});
    it.req_type = REQ_TICK;
    return it;
  endfunction

  function automatic logic [CmdW-1:0] pick_cmd();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return {1'b0, drive_sb.pwm_top};
      5:       return -{1'b0, drive_sb.pwm_top};
      default: return CmdW'($urandom);
    endcase
  endfunction

  function automatic item_t random_item(int unsigned tick_pct, int unsigned own_pct);
    logic [DataW-1:0] data;
    data = {pick_cmd(), pick_cmd(), pick_cmd(), pick_cmd()};
    if ($urandom_range(0, 99) < tick_pct)
      return tick_item();
    if ($urandom_range(0, 99) < own_pct) begin
      if ($urandom_range(0, 4) == 0)
        return frame_item(drive_sb.own_id, 1'b0, LenW'($urandom_range(0, 7)), data);
      return frame_item(drive_sb.own_id, 1'b0, LenW'($urandom_range(8, 15)), data);
    end
    // noise: extended frames (often on our id) and traffic for other nodes
    if ($urandom_range(0, 1) == 0)
      return frame_item($urandom_range(0, 1) ? drive_sb.own_id : IdW'($urandom), 1'b1,
                        LenW'($urandom), data);
    return frame_item(IdW'($urandom), 1'b0, LenW'($urandom), data);
  endfunction

  // Leaves in_valid high on return so the next beat can follow back to back.
  task automatic send_beat(input item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= it.req_type;
    frame_id       <= it.frame_id;
    frame_extended <= it.frame_extended;
    frame_len      <= it.frame_len;
    payload        <= it.payload;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    drive_sb.note_beat(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_sb.awaited_drive_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    drive_sb.load_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CfgDatW-1:0] id_word, tmo, top);
    settle();
    program_reg(CFG_OWN_ID, id_word);
    program_reg(CFG_TIMEOUT, tmo);
    program_reg(CFG_PWM_TOP, top);
    program_reg(CfgNoReg, CfgDatW'($urandom));
  endtask

  initial begin : stimulus
    int unsigned tick_pct;
    int unsigned own_pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on <= 1'b1;

    // default registers: command decode corners
    send_beat(tick_item());
    send_beat(frame_item(OWN_ID_RESET, 1'b0, 4'd8, cmds(16'h7FFF, 16'h8000, 16'h0000, 16'h0001)));
    send_beat(frame_item(OWN_ID_RESET, 1'b0, 4'd15, cmds(16'hFFFF, 16'h3039, 16'h8001, 16'h7FFE)));
    send_beat(frame_item(OWN_ID_RESET, 1'b1, 4'd8, cmds(16'h1111, 16'h2222, 16'h3333, 16'h4444)));
    send_beat(frame_item(11'h7FF, 1'b0, 4'd8, cmds(16'h0000, 16'h0000, 16'h0000, 16'h0000)));
    send_beat(frame_item(11'h000, 1'b0, 4'd15, {2{32'hFFFF_FFFF}}));
    send_beat(frame_item(OWN_ID_RESET, 1'b0, 4'd7, cmds(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF)));
    send_beat(frame_item(OWN_ID_RESET, 1'b0, 4'd9, cmds(16'h8000, 16'h8000, 16'h8000, 16'h8000)));
    send_beat(frame_item(OWN_ID_RESET, 1'b0, 4'd0, cmds(16'h1234, 16'h1234, 16'h1234, 16'h1234)));
    send_beat(frame_item(OWN_ID_RESET, 1'b0, 4'd8, cmds(16'h1234, 16'hFFFF, 16'h7FFF, 16'h8000)));

    // lower pwm_top: stored duties hold until the next command
    settle();
    program_reg(CFG_PWM_TOP, 16'd100);
    send_beat(tick_item());
    send_beat(frame_item(11'h155, 1'b0, 4'd8, {2{32'h5555_AAAA}}));
    send_beat(frame_item(OWN_ID_RESET, 1'b0, 4'd8, cmds(16'h7FFF, 16'h8000, 16'h0064, 16'hFF9B)));

    // zero timeout, zero pwm_top, top identifier
    configure(16'h07FF, 16'h0000, 16'h0000);
    send_beat(tick_item());
    send_beat(frame_item(11'h7FF, 1'b0, 4'd8, cmds(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF)));
    send_beat(frame_item(11'h000, 1'b0, 4'd8, cmds(16'h0000, 16'h0000, 16'h0000, 16'h0000)));

    // upper data bits must be dropped; then own-id silence, then bus silence
    configure(16'hF800, 16'h0002, 16'hFFFF);
    send_beat(frame_item(11'h000, 1'b0, 4'd8, cmds(16'h0100, 16'hFF00, 16'h7FFF, 16'h8000)));
    send_beat(tick_item());
    send_beat(frame_item(11'h005, 1'b0, 4'd3, {2{32'h0F0F_F0F0}}));
    send_beat(tick_item());
    send_beat(tick_item());
    send_beat(tick_item());
    send_beat(frame_item(11'h000, 1'b0, 4'd8, cmds(16'h0001, 16'h0002, 16'h0003, 16'h0004)));

    for (int p = 0; p < 8; p++) begin
      configure({5'($urandom), 11'($urandom)},
                (p == 5) ? 16'hFFFF : 16'($urandom_range(0, 12)),
                (p == 1) ? 16'h0000 : (p == 4) ? 16'h7FFF : 16'($urandom));
      idle_on <= (p < 6);
      if (p == 2) hold_asks <= hold_asks + 8'd1;
      tick_pct = $urandom_range(25, 55);
      own_pct  = (p % 2) ? $urandom_range(15, 40) : $urandom_range(60, 90);
      repeat (90) send_beat(random_item(tick_pct, own_pct));
    end

    // long silence: the failsafe holds tick after tick until traffic returns
    configure({5'($urandom), 11'(drive_sb.own_id)}, SilenceTimeout, 16'h7FFF);
    send_beat(frame_item(drive_sb.own_id, 1'b0, 4'd8,
                         cmds(16'h0FFF, 16'hF001, 16'h7FFF, 16'h8000)));
    repeat (SilenceTicks) send_beat(tick_item());
    send_beat(frame_item(drive_sb.own_id + 11'd1, 1'b0, 4'd8, {2{32'h1357_9BDF}}));
    send_beat(frame_item(drive_sb.own_id, 1'b0, 4'd8,
                         cmds(16'h0042, 16'hFFBE, 16'h0000, 16'h7FFF)));

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d ticks, %0d full and %0d short own frames, %0d other frames, %0d writes",
             drive_sb.ticks, drive_sb.own_full, drive_sb.own_short, drive_sb.other_frames,
             drive_sb.writes);
    $display("Failsafe held on %0d beats for bus silence and %0d for own-id silence",
             drive_sb.bus_silent, drive_sb.own_silent);
    if (drive_sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
